// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/core/tpi_pkg.sv
// shared types, constants and tables of the trapezoidal integrator
package tpi_pkg;

    localparam int IN_W        = 24;
    localparam int CFG_W       = 21;
    localparam int OUT_W       = 64;
    localparam int F_W         = 56;
    localparam int POINT_GUARD = 22;
    localparam int PT_W        = 48;
    localparam int Q_W         = 36;
    localparam int RED_W       = 48;
    localparam int DIV_W       = 80;
    localparam int DVS_W       = 22;
    localparam int MAG_W       = 24;

    localparam logic [CFG_W-1:0] CFG_RESET = 21'd1000000;

    localparam logic [1:0] SEL_SQUARE = 2'd0;
    localparam logic [1:0] SEL_CUBE   = 2'd1;
    localparam logic [1:0] SEL_SINE   = 2'd2;

    localparam logic signed [Q_W-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [Q_W-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [Q_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [Q_W-1:0] Q30_GAIN    = 36'sd652032874;
    localparam logic [RED_W-1:0]      Q30_TWO_PI_U = 48'd6746518852;

    // subtract stages needed to reduce the scaled angle below two pi
    function automatic int red_steps(int frac);
        return (frac < 21) ? (21 - frac) : 1;
    endfunction

    function automatic logic signed [Q_W-1:0] atan_q30(int i);
        logic signed [Q_W-1:0] r;
        case (i)
            0:  r = 36'sd843314856;
            1:  r = 36'sd497837829;
            2:  r = 36'sd263043836;
            3:  r = 36'sd133525158;
            4:  r = 36'sd67021686;
            5:  r = 36'sd33543515;
            6:  r = 36'sd16775850;
            7:  r = 36'sd8388437;
            8:  r = 36'sd4194282;
            9:  r = 36'sd2097149;
            10: r = 36'sd1048575;
            11: r = 36'sd524287;
            12: r = 36'sd262143;
            13: r = 36'sd131071;
            14: r = 36'sd65535;
            15: r = 36'sd32767;
            16: r = 36'sd16383;
            17: r = 36'sd8191;
            18: r = 36'sd4095;
            19: r = 36'sd2047;
            20: r = 36'sd1023;
            21: r = 36'sd511;
            22: r = 36'sd255;
            23: r = 36'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/tpi_poly.sv
// four stage pipeline for the square and doubled cube integrands
module tpi_poly #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic signed [tpi_pkg::IN_W-1:0]     x,
    output logic signed [tpi_pkg::F_W-1:0]      square,
    output logic signed [tpi_pkg::F_W-1:0]      cube
);

    logic signed [47:0]              sq_full;
    logic [39:0]                     sq_reg;
    logic [39:0]                     sq2_reg;
    logic [39:0]                     sq3_reg;
    logic signed [tpi_pkg::IN_W-1:0] x1_reg;
    logic signed [48:0]              plo_reg;
    logic signed [40:0]              phi_reg;
    logic signed [63:0]              prod_reg;

    assign sq_full = x * x;

    always_ff @(posedge clk)
    begin
        sq_reg   <= 40'(sq_full >>> FRAC_BITS);
        x1_reg   <= x;
        // split the cube product into two partial products
        plo_reg  <= $signed({1'b0, sq_reg[23:0]}) * x1_reg;
        phi_reg  <= $signed({1'b0, sq_reg[39:24]}) * x1_reg;
        sq2_reg  <= sq_reg;
        prod_reg <= (64'(phi_reg) <<< 24) + 64'(plo_reg);
        sq3_reg  <= sq2_reg;
        cube     <= tpi_pkg::F_W'((prod_reg <<< 1) >>> FRAC_BITS);
        square   <= $signed(tpi_pkg::F_W'(sq3_reg));
    end

endmodule

// File: rtl/core/tpi_sine.sv
// pipelined range reduction and rotation cordic for the sine integrand
module tpi_sine #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                clk,
    input  logic signed [tpi_pkg::IN_W-1:0]     x,
    output logic signed [tpi_pkg::F_W-1:0]      sine
);

    localparam int RED = tpi_pkg::red_steps(FRAC_BITS);
    localparam int QW  = tpi_pkg::Q_W;

    logic signed [tpi_pkg::RED_W-1:0] v;
    logic [tpi_pkg::RED_W-1:0]        mag0;
    logic [tpi_pkg::RED_W-1:0]        mag_reg [RED];
    logic                             neg_reg [RED];
    logic signed [QW-1:0]             rm;
    logic signed [QW-1:0]             r;
    logic signed [QW-1:0]             xc_reg [CORDIC_STEPS+1];
    logic signed [QW-1:0]             yc_reg [CORDIC_STEPS+1];
    logic signed [QW-1:0]             z_reg  [CORDIC_STEPS+1];

    assign v    = tpi_pkg::RED_W'(x) <<< (30 - FRAC_BITS);
    assign mag0 = v[tpi_pkg::RED_W-1] ? tpi_pkg::RED_W'(-v) : tpi_pkg::RED_W'(v);

    // remainder of the magnitude by two pi, one binary multiple per stage
    for (genvar k = 0; k < RED; k++) begin : g_red
        localparam logic [tpi_pkg::RED_W-1:0] SUB = tpi_pkg::Q30_TWO_PI_U << (RED - 1 - k);
        logic [tpi_pkg::RED_W-1:0] m_in;
        logic                      n_in;
        if (k == 0) begin : g_first
            assign m_in = mag0;
            assign n_in = v[tpi_pkg::RED_W-1];
        end else begin : g_next
            assign m_in = mag_reg[k-1];
            assign n_in = neg_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            mag_reg[k] <= (m_in >= SUB) ? m_in - SUB : m_in;
            neg_reg[k] <= n_in;
        end
    end

    // fold into minus half pi to half pi
    assign rm = $signed(QW'(mag_reg[RED-1]));
    always_comb
    begin
        r = neg_reg[RED-1] ? -rm : rm;
        if (r > tpi_pkg::Q30_PI)
            r = r - tpi_pkg::Q30_TWO_PI;
        if (r < -tpi_pkg::Q30_PI)
            r = r + tpi_pkg::Q30_TWO_PI;
        if (r > tpi_pkg::Q30_HALF_PI)
            r = tpi_pkg::Q30_PI - r;
        if (r < -tpi_pkg::Q30_HALF_PI)
            r = -tpi_pkg::Q30_PI - r;
    end

    always_ff @(posedge clk)
    begin
        xc_reg[0] <= tpi_pkg::Q30_GAIN;
        yc_reg[0] <= '0;
        z_reg[0]  <= r;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        localparam logic signed [QW-1:0] AT = tpi_pkg::atan_q30(i);
        always_ff @(posedge clk)
        begin
            if (z_reg[i] >= 0)
            begin
                xc_reg[i+1] <= xc_reg[i] - (yc_reg[i] >>> i);
                yc_reg[i+1] <= yc_reg[i] + (xc_reg[i] >>> i);
                z_reg[i+1]  <= z_reg[i] - AT;
            end
            else
            begin
                xc_reg[i+1] <= xc_reg[i] + (yc_reg[i] >>> i);
                yc_reg[i+1] <= yc_reg[i] - (xc_reg[i] >>> i);
                z_reg[i+1]  <= z_reg[i] + AT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sine <= tpi_pkg::F_W'(yc_reg[CORDIC_STEPS] >>> (30 - FRAC_BITS));
    end

endmodule

// File: rtl/core/tpi_div.sv
// restoring divider, one quotient bit per cycle
module tpi_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tpi_pkg::DIV_W-1:0]     dividend,
    input  logic [tpi_pkg::DVS_W-1:0]     divisor,
    output logic [tpi_pkg::DIV_W-1:0]     quotient,
    output logic                          done
);

    localparam int DW = tpi_pkg::DIV_W;
    localparam int VW = tpi_pkg::DVS_W;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] q_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    assign trial = {rem_reg, q_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(DW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            q_reg   <= {q_reg[DW-2:0], fits};
            rem_reg <= fits ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

// File: rtl/core/trapezoidal_integrator.sv
// trapezoidal integrator top level: sequencer, sample pipeline and accumulator
//
// A request is taken when start is high and busy is low; lower_bound,
// upper_bound and function_select are sampled then. busy stays high until
// the result is shown. The result appears on integral and overflow with done
// high for one cycle; the receiver cannot hold it off.
// num_intervals is to be written through cfg_wr_en / cfg_wr_data while idle;
// the block does not enforce this. Zero counts as one and counts above
// MAX_INTERVALS are clipped.
// Per request: a setup state that starts the divide for the step size,
// then one sample per cycle for n+1 points into the function pipeline, a
// drain until the pipeline is empty, the product in states S_MUL_LO,
// S_MUL_HI and S_SUM, the state S_FSTART to start the divider and a divide
// by 2n, then the result with done.
// The next request can be taken at the edge that takes the result, so one
// request runs at a time.
// The sample rate is one per cycle, set by the pipelined integrand units;
// the shared divider retires one quotient bit per cycle for both divides.
// Reset returns to idle, clears the accumulator and sets n to 1000000.
`include "assert_macros.svh"

module trapezoidal_integrator #(
    parameter int FRAC_BITS     = 16,
    parameter int MAX_INTERVALS = 1048576,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [tpi_pkg::IN_W-1:0]        lower_bound,
    input  logic signed [tpi_pkg::IN_W-1:0]        upper_bound,
    input  logic [1:0]                             function_select,
    input  logic                                   cfg_wr_en,
    input  logic [tpi_pkg::CFG_W-1:0]              cfg_wr_data,
    output logic                                   done,
    output logic signed [tpi_pkg::OUT_W-1:0]       integral,
    output logic                                   overflow
);

    localparam int SLAT = tpi_pkg::red_steps(FRAC_BITS) + CORDIC_STEPS + 2;
    localparam int PD   = SLAT - 4;
    localparam int NW   = tpi_pkg::CFG_W;
    localparam int DW   = tpi_pkg::DIV_W;
    localparam int FW   = tpi_pkg::F_W;
    localparam int PW   = tpi_pkg::PT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SETUP  = 4'd1;
    localparam logic [3:0] S_STEP   = 4'd2;
    localparam logic [3:0] S_RUN    = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_MUL_LO = 4'd5;
    localparam logic [3:0] S_MUL_HI = 4'd6;
    localparam logic [3:0] S_SUM    = 4'd7;
    localparam logic [3:0] S_FSTART = 4'd8;
    localparam logic [3:0] S_FDIV   = 4'd9;

    logic [3:0]                       state_reg;
    logic [NW-1:0]                    num_intervals_reg;
    logic [NW-1:0]                    n_eff;
    logic [NW-1:0]                    n_reg;
    logic signed [tpi_pkg::IN_W-1:0]  a_reg;
    logic signed [tpi_pkg::IN_W-1:0]  b_reg;
    logic [1:0]                       sel_reg;
    logic signed [24:0]               d;
    logic [tpi_pkg::MAG_W-1:0]        d_mag;
    logic signed [PW-1:0]             step_size_reg;
    logic signed [PW-1:0]             current_point_reg;
    logic signed [PW-1:0]             cp_next;
    logic [NW:0]                      point_counter_reg;
    logic signed [tpi_pkg::IN_W-1:0]  x_reg;
    logic                             v0_reg;
    logic                             w0_reg;
    logic [SLAT-1:0]                  vl_reg;
    logic [SLAT-1:0]                  wl_reg;
    logic signed [FW-1:0]             sq_out;
    logic signed [FW-1:0]             cu_out;
    logic signed [FW-1:0]             sine_out;
    logic signed [FW-1:0]             pd_sq_reg [PD];
    logic signed [FW-1:0]             pd_cu_reg [PD];
    logic signed [FW-1:0]             fx;
    logic signed [65:0]               acc_sum;
    logic signed [63:0]               point_accumulator_reg;
    logic                             flag_reg;
    logic [63:0]                      acc_mag;
    logic [31:0]                      mul_op;
    logic [55:0]                      mul_res;
    logic [55:0]                      prod_lo_reg;
    logic [55:0]                      prod_hi_reg;
    logic [87:0]                      prod_sum;
    logic [DW-1:0]                    prod_dvd_reg;
    logic                             div_start;
    logic [DW-1:0]                    div_dividend;
    logic [tpi_pkg::DVS_W-1:0]        div_divisor;
    logic [DW-1:0]                    div_q;
    logic                             div_done;
    logic [63:0]                      mag;
    logic                             res_neg;
    logic                             done_reg;
    logic signed [63:0]               integral_reg;
    logic                             overflow_reg;

    assign busy = (state_reg != S_IDLE);

    assign n_eff = (num_intervals_reg == '0) ? NW'(1) :
                   (32'(num_intervals_reg) > MAX_INTERVALS) ? NW'(MAX_INTERVALS) :
                   num_intervals_reg;

    assign d       = 25'(b_reg) - 25'(a_reg);
    assign d_mag   = d[24] ? tpi_pkg::MAG_W'(-d) : tpi_pkg::MAG_W'(d);
    assign cp_next = current_point_reg + step_size_reg;

    tpi_poly #(
        .FRAC_BITS (FRAC_BITS)
    ) u_poly (
        .clk    (clk),
        .x      (x_reg),
        .square (sq_out),
        .cube   (cu_out)
    );

    tpi_sine #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_sine (
        .clk  (clk),
        .x    (x_reg),
        .sine (sine_out)
    );

    // line up the polynomial results with the sine latency
    for (genvar k = 0; k < PD; k++) begin : g_pd
        always_ff @(posedge clk)
        begin
            if (k == 0)
            begin
                pd_sq_reg[k] <= sq_out;
                pd_cu_reg[k] <= cu_out;
            end
            else
            begin
                pd_sq_reg[k] <= pd_sq_reg[(k == 0) ? 0 : k-1];
                pd_cu_reg[k] <= pd_cu_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_comb
    begin
        case (sel_reg)
            tpi_pkg::SEL_SQUARE: fx = pd_sq_reg[PD-1];
            tpi_pkg::SEL_CUBE:   fx = pd_cu_reg[PD-1];
            tpi_pkg::SEL_SINE:   fx = sine_out;
            default:             fx = '0;
        endcase
    end

    // interior points count twice; one wide add, then saturate
    assign acc_sum = 66'(point_accumulator_reg) + (66'(fx) <<< wl_reg[SLAT-1]);

    assign acc_mag  = point_accumulator_reg[63] ? 64'(-point_accumulator_reg)
                                                : 64'(point_accumulator_reg);
    assign mul_op   = (state_reg == S_MUL_LO) ? acc_mag[31:0] : acc_mag[63:32];
    assign mul_res  = mul_op * d_mag;
    assign prod_sum = 88'(prod_lo_reg) + (88'(prod_hi_reg) << 32);

    assign div_start    = (state_reg == S_SETUP) || (state_reg == S_FSTART);
    assign div_dividend = (state_reg == S_SETUP) ? DW'({d_mag, 22'b0}) : prod_dvd_reg;
    assign div_divisor  = (state_reg == S_SETUP) ? {1'b0, n_reg} : {n_reg, 1'b0};

    tpi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    assign mag     = div_q[63:0];
    assign res_neg = point_accumulator_reg[63] != d[24];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= S_IDLE;
            num_intervals_reg     <= tpi_pkg::CFG_RESET;
            v0_reg                <= 1'b0;
            vl_reg                <= '0;
            done_reg              <= 1'b0;
            point_accumulator_reg <= '0;
            flag_reg              <= 1'b0;
            current_point_reg     <= '0;
            step_size_reg         <= '0;
            point_counter_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                num_intervals_reg <= cfg_wr_data;
            done_reg <= 1'b0;
            v0_reg   <= 1'b0;
            vl_reg   <= {vl_reg[SLAT-2:0], v0_reg};

            if (vl_reg[SLAT-1])
            begin
                if (!acc_sum[65] && (acc_sum[64] || acc_sum[63]))
                begin
                    point_accumulator_reg <= 64'h7FFF_FFFF_FFFF_FFFF;
                    flag_reg              <= 1'b1;
                end
                else if (acc_sum[65] && !(acc_sum[64] && acc_sum[63]))
                begin
                    point_accumulator_reg <= 64'h8000_0000_0000_0000;
                    flag_reg              <= 1'b1;
                end
                else
                begin
                    point_accumulator_reg <= acc_sum[63:0];
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_SETUP;
                end
                S_SETUP:
                begin
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    if (div_done)
                    begin
                        step_size_reg     <= d[24] ? -PW'(div_q[46:0]) : PW'(div_q[46:0]);
                        current_point_reg <= PW'(a_reg) <<< tpi_pkg::POINT_GUARD;
                        point_counter_reg <= '0;
                        point_accumulator_reg <= '0;
                        flag_reg          <= 1'b0;
                        state_reg         <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    v0_reg            <= 1'b1;
                    point_counter_reg <= point_counter_reg + 1'b1;
                    if (point_counter_reg >= (NW+1)'(2))
                        current_point_reg <= cp_next;
                    if (point_counter_reg == {1'b0, n_reg})
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (!v0_reg && (vl_reg == '0))
                        state_reg <= S_MUL_LO;
                end
                S_MUL_LO:
                begin
                    state_reg <= S_MUL_HI;
                end
                S_MUL_HI:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    state_reg <= S_FSTART;
                end
                S_FSTART:
                begin
                    state_reg <= S_FDIV;
                end
                S_FDIV:
                begin
                    if (div_done)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        wl_reg <= {wl_reg[SLAT-2:0], w0_reg};
        if (state_reg == S_IDLE && start)
        begin
            a_reg   <= lower_bound;
            b_reg   <= upper_bound;
            sel_reg <= function_select;
            n_reg   <= n_eff;
        end
        // endpoints first with single weight, then interior samples
        if (point_counter_reg == '0)
        begin
            x_reg  <= a_reg;
            w0_reg <= 1'b0;
        end
        else if (point_counter_reg == (NW+1)'(1))
        begin
            x_reg  <= b_reg;
            w0_reg <= 1'b0;
        end
        else
        begin
            x_reg  <= cp_next[tpi_pkg::POINT_GUARD +: tpi_pkg::IN_W];
            w0_reg <= 1'b1;
        end
        if (state_reg == S_MUL_LO)
            prod_lo_reg <= mul_res;
        if (state_reg == S_MUL_HI)
            prod_hi_reg <= mul_res;
        if (state_reg == S_SUM)
            prod_dvd_reg <= DW'(prod_sum >> FRAC_BITS);
        if (state_reg == S_FDIV && div_done)
        begin
            if (div_q[DW-1:64] != '0)
            begin
                overflow_reg <= 1'b1;
                integral_reg <= res_neg ? 64'sh8000_0000_0000_0000
                                        : 64'sh7FFF_FFFF_FFFF_FFFF;
            end
            else if (res_neg)
            begin
                overflow_reg <= flag_reg || (mag > 64'h8000_0000_0000_0000);
                integral_reg <= (mag >= 64'h8000_0000_0000_0000) ? 64'sh8000_0000_0000_0000
                                                                 : -$signed(mag);
            end
            else if (mag[63])
            begin
                overflow_reg <= 1'b1;
                integral_reg <= 64'sh7FFF_FFFF_FFFF_FFFF;
            end
            else
            begin
                overflow_reg <= flag_reg;
                integral_reg <= $signed(mag);
            end
        end
    end

    assign done     = done_reg;
    assign integral = integral_reg;
    assign overflow = overflow_reg;

    `ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy, "result shown while still busy")
    `ASSERT_IMPL(a_idle_empty, clk, rst_n, state_reg == S_IDLE, !v0_reg && (vl_reg == '0), "samples in flight while idle")
    `ASSERT_IMPL(a_issue_run, clk, rst_n, v0_reg, (state_reg == S_RUN) || (state_reg == S_DRAIN), "sample issued outside run")
    `ASSERT_IMPL(a_div_sync, clk, rst_n, div_done, (state_reg == S_STEP) || (state_reg == S_FDIV), "divider finished in wrong state")

endmodule
